// File: rtl/rdhc_pkg.sv
// Shared types and constants for the roof drive heartbeat controller.
// No dependencies; used by every module in rtl/.
package rdhc_pkg;

    localparam int unsigned CNT_W      = 8;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 32;

    // Host command bytes
    localparam logic [7:0] CMD_OPEN  = 8'hF1;
    localparam logic [7:0] CMD_CLOSE = 8'hF2;
    localparam logic [7:0] CMD_STOP  = 8'hF3;
    localparam logic [7:0] HB_OFF    = 8'h00;
    localparam logic [7:0] HB_MAX    = 8'd240;
    localparam logic [7:0] HB_HOLD   = 8'hFF;

    localparam logic [CNT_W-1:0] OPEN_TIMEOUT_RST  = 8'd45;
    localparam logic [CNT_W-1:0] CLOSE_TIMEOUT_RST = 8'd110;

    // Configuration register indexes
    localparam logic CFG_OPEN_TIMEOUT  = 1'b0;
    localparam logic CFG_CLOSE_TIMEOUT = 1'b1;

    typedef enum logic {
        KIND_HOST = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_UNKNOWN       = 3'd0,
        ST_CLOSED        = 3'd1,
        ST_OPEN          = 3'd2,
        ST_CLOSING       = 3'd3,
        ST_OPENING       = 3'd4,
        ST_FORCE_CLOSING = 3'd5,
        ST_FORCE_CLOSED  = 3'd6
    } t_roof_status;

    typedef struct packed {
        logic [CNT_W-1:0] hb;
        logic             tripped;
        logic [CNT_W-1:0] close_cnt;
        logic [CNT_W-1:0] open_cnt;
        t_roof_status     status;
        logic             open_latch;
        logic             close_latch;
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] open_timeout;
        logic [CNT_W-1:0] close_timeout;
    } t_cfg;

endpackage

// File: rtl/roof_drive_heartbeat_controller_core.sv
// Top level of the roof drive heartbeat controller.
// Depends on rdhc_pkg, rdhc_cfg and rdhc_step.
//
// Roof drive controller with heartbeat watchdog. Each input item is a host
// byte (tuser 0) or a half-second tick carrying limit-switch levels (tuser 1),
// and each produces exactly one result item: a snapshot of status, drive
// enables, heartbeat and both step counters after that item. Timing: an item
// sits in the input register, and its state update is done in the cycle it
// moves to the result register; one item is taken every clock while the
// result side is not stalled. The controller state register is the only
// feedback loop. The result register and the input register decouple the
// two stream sides only in part: a stalled result stops the next item from
// being taken once the input register holds an item. Timeout registers are
// written through the cfg channel (index 0 open timeout, index 1 close timeout),
// which is always ready; write them only while no item is in flight.
module roof_drive_heartbeat_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] host_byte, [8] closed_limit_hit, [9] open_limit_hit, [15:10] zero
    input  logic [rdhc_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // [0] kind: 0 host byte, 1 tick
    input  logic        i_s_axis_tuser,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] roof_status, [3] open_drive, [4] close_drive, [12:5] heartbeat_left,
    // [20:13] close_ticks_left, [28:21] open_ticks_left, [29] watchdog_tripped,
    // [31:30] zero
    output logic [rdhc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [rdhc_pkg::CNT_W-1:0] i_cfg_data
);

    rdhc_pkg::t_cfg   w_cfg;
    rdhc_pkg::t_state r_st;
    rdhc_pkg::t_state n_st;

    logic                               r_in_valid;
    rdhc_pkg::t_kind                    r_in_kind;
    logic [9:0]                         r_in_data;
    logic                               r_out_valid;
    logic [rdhc_pkg::OUT_DATA_W-1:0]    r_out_data;
    logic                               w_advance;

    rdhc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    // item moves from input register into result register
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_kind <= rdhc_pkg::t_kind'(i_s_axis_tuser);
            r_in_data <= i_s_axis_tdata[9:0];
        end
    end

    rdhc_step u_step (
        .i_st         (r_st),
        .i_cfg        (w_cfg),
        .i_kind       (r_in_kind),
        .i_host_byte  (r_in_data[7:0]),
        .i_closed_hit (r_in_data[8]),
        .i_open_hit   (r_in_data[9]),
        .o_st         (n_st)
    );

    // controller state, committed once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.hb          <= '0;
            r_st.tripped     <= 1'b0;
            r_st.close_cnt   <= '0;
            r_st.open_cnt    <= '0;
            r_st.status      <= rdhc_pkg::ST_UNKNOWN;
            r_st.open_latch  <= 1'b0;
            r_st.close_latch <= 1'b0;
        end else if (w_advance) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {2'b00, n_st.tripped, n_st.open_cnt, n_st.close_cnt,
                           n_st.hb, n_st.close_latch, n_st.open_latch,
                           n_st.status};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // drive enables track their counters right after a tick
    a_drive_follows_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_kind == rdhc_pkg::KIND_TICK) |=>
        (r_st.open_latch == (r_st.open_cnt != '0)) &&
        (r_st.close_latch == (r_st.close_cnt != '0)))
        else $error("drive enable does not match counter after tick");

    // a tripped watchdog keeps the heartbeat disabled
    a_trip_hb_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.tripped |-> (r_st.hb == '0))
        else $error("heartbeat running while tripped");

    a_hb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.hb <= rdhc_pkg::HB_MAX)
        else $error("heartbeat above maximum");

    // never drive both motors
    a_one_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_st.open_cnt != '0) && (r_st.close_cnt != '0)))
        else $error("open and close counters both running");

endmodule

// File: rtl/rdhc_cfg.sv
// Timeout configuration registers of the roof drive heartbeat controller.
// Depends on rdhc_pkg.
module rdhc_cfg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_index,
    input  logic [rdhc_pkg::CNT_W-1:0] i_cfg_data,
    output logic                     o_cfg_ready,
    output rdhc_pkg::t_cfg           o_cfg
);

    rdhc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_timeout  <= rdhc_pkg::OPEN_TIMEOUT_RST;
            r_cfg.close_timeout <= rdhc_pkg::CLOSE_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rdhc_pkg::CFG_OPEN_TIMEOUT:  r_cfg.open_timeout  <= i_cfg_data;
                rdhc_pkg::CFG_CLOSE_TIMEOUT: r_cfg.close_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/rdhc_step.sv
// Next-state logic for one item: host byte decode or half-second tick update.
// Depends on rdhc_pkg.
module rdhc_step (
    input  rdhc_pkg::t_state         i_st,
    input  rdhc_pkg::t_cfg           i_cfg,
    input  rdhc_pkg::t_kind          i_kind,
    input  logic [7:0]               i_host_byte,
    input  logic                     i_closed_hit,
    input  logic                     i_open_hit,
    output rdhc_pkg::t_state         o_st
);

    rdhc_pkg::t_state n_st;

    always_comb begin
        n_st = i_st;
        if (i_kind == rdhc_pkg::KIND_HOST) begin
            case (i_host_byte)
                rdhc_pkg::CMD_OPEN: begin
                    n_st.close_cnt = '0;
                    n_st.open_cnt  = i_cfg.open_timeout;
                end
                rdhc_pkg::CMD_CLOSE: begin
                    n_st.open_cnt  = '0;
                    n_st.close_cnt = i_cfg.close_timeout;
                end
                rdhc_pkg::CMD_STOP: begin
                    if (i_st.open_cnt > 8'd1)  n_st.open_cnt  = 8'd1;
                    if (i_st.close_cnt > 8'd1) n_st.close_cnt = 8'd1;
                end
                default: ;
            endcase
            if (i_host_byte <= rdhc_pkg::HB_MAX) begin
                // zero byte: clear trip, cancel close, disable heartbeat
                if (i_host_byte == rdhc_pkg::HB_OFF) begin
                    n_st.tripped   = 1'b0;
                    n_st.close_cnt = '0;
                end
                if (!n_st.tripped) n_st.hb = i_host_byte;
            end
        end else begin
            n_st.status = rdhc_pkg::ST_UNKNOWN;
            // heartbeat countdown and forced close on expiry
            if (i_st.hb != rdhc_pkg::HB_HOLD && i_st.hb != '0) begin
                n_st.hb = i_st.hb - 8'd1;
                if (n_st.hb == '0) begin
                    n_st.tripped   = 1'b1;
                    n_st.open_cnt  = '0;
                    n_st.close_cnt = i_cfg.close_timeout;
                end
            end
            // limit switches, closed has priority
            if (i_closed_hit) begin
                n_st.status    = n_st.tripped ? rdhc_pkg::ST_FORCE_CLOSED
                                              : rdhc_pkg::ST_CLOSED;
                n_st.close_cnt = '0;
            end else if (i_open_hit) begin
                n_st.status   = rdhc_pkg::ST_OPEN;
                n_st.open_cnt = '0;
            end
            // step whichever motor is running
            if (n_st.close_cnt != '0) begin
                n_st.status    = n_st.tripped ? rdhc_pkg::ST_FORCE_CLOSING
                                              : rdhc_pkg::ST_CLOSING;
                n_st.close_cnt = n_st.close_cnt - 8'd1;
            end else if (n_st.open_cnt != '0) begin
                n_st.status   = rdhc_pkg::ST_OPENING;
                n_st.open_cnt = n_st.open_cnt - 8'd1;
            end
            n_st.open_latch  = (n_st.open_cnt != '0);
            n_st.close_latch = (n_st.close_cnt != '0);
        end
    end

    assign o_st = n_st;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for roof_drive_heartbeat_controller_core.
// Depends on rdhc_pkg and the core; predicts every result item and checks it field by field.

module testbench;

    localparam int unsigned WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
    localparam int unsigned DRAIN_CYCLES   = 4;     // watch window after draining, for stray result items

    // One result item, unpacked
    typedef struct {
        rdhc_pkg::t_roof_status     status;
        logic                       open_drive;
        logic                       close_drive;
        logic [rdhc_pkg::CNT_W-1:0] heartbeat_left;
        logic [rdhc_pkg::CNT_W-1:0] close_left;
        logic [rdhc_pkg::CNT_W-1:0] open_left;
        logic                       tripped;
    } t_roof_snapshot;

    // DUT ports
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [rdhc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                            i_s_axis_tuser;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    logic [rdhc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic                            i_cfg_index;
    logic [rdhc_pkg::CNT_W-1:0]      i_cfg_data;

    // Predicted controller state and its timeout settings
    logic [rdhc_pkg::CNT_W-1:0] open_timeout;
    logic [rdhc_pkg::CNT_W-1:0] close_timeout;
    logic [rdhc_pkg::CNT_W-1:0] hb_count;
    logic                       hb_tripped;
    logic [rdhc_pkg::CNT_W-1:0] close_count;
    logic [rdhc_pkg::CNT_W-1:0] open_count;
    rdhc_pkg::t_roof_status     roof_status;
    logic                       open_latch;
    logic                       close_latch;

    t_roof_snapshot expected_snapshots[$];

    int unsigned error_count;
    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;
    bit          tx_gaps;     // sender inserts gaps between bursts
    bit          rx_stalls;   // receiver follows its stall pattern
    bit          rx_ready_phase;
    int unsigned rx_left;

    roof_drive_heartbeat_controller_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one accepted item to the shadow state and queues
    // the snapshot the core must return for it.
    // ------------------------------------------------------------------
    task automatic roof_predict(input rdhc_pkg::t_kind kind, input logic [7:0] hbyte,
                                input logic closed_hit, input logic open_hit);
        rdhc_pkg::t_roof_status st;
        t_roof_snapshot         snap;
        if (kind == rdhc_pkg::KIND_HOST) begin
            if (hbyte == rdhc_pkg::CMD_OPEN) begin
                close_count = '0;
                open_count  = open_timeout;
            end else if (hbyte == rdhc_pkg::CMD_CLOSE) begin
                open_count  = '0;
                close_count = close_timeout;
            end else if (hbyte == rdhc_pkg::CMD_STOP) begin
                if (open_count > 8'd1)
                    open_count = 8'd1;
                if (close_count > 8'd1)
                    close_count = 8'd1;
            end
            // command bytes above the heartbeat range leave it alone
            if (hbyte <= rdhc_pkg::HB_MAX) begin
                if (hbyte == rdhc_pkg::HB_OFF) begin
                    hb_tripped  = 1'b0;
                    close_count = '0;
                end
                if (!hb_tripped)
                    hb_count = hbyte;
            end
            // status and drive latches hold their last tick values
        end else begin
            st = rdhc_pkg::ST_UNKNOWN;
            if (hb_count != rdhc_pkg::HB_HOLD && hb_count != '0) begin
                hb_count = hb_count - 8'd1;
                if (hb_count == '0) begin
                    // heartbeat lost: force a close
                    hb_tripped  = 1'b1;
                    open_count  = '0;
                    close_count = close_timeout;
                end
            end
            // closed limit has priority over open limit
            if (closed_hit) begin
                st          = hb_tripped ? rdhc_pkg::ST_FORCE_CLOSED
                                         : rdhc_pkg::ST_CLOSED;
                close_count = '0;
            end else if (open_hit) begin
                st         = rdhc_pkg::ST_OPEN;
                open_count = '0;
            end
            if (close_count != '0) begin
                st          = hb_tripped ? rdhc_pkg::ST_FORCE_CLOSING
                                         : rdhc_pkg::ST_CLOSING;
                close_count = close_count - 8'd1;
            end else if (open_count != '0) begin
                st         = rdhc_pkg::ST_OPENING;
                open_count = open_count - 8'd1;
            end
            roof_status = st;
            // drive follows counter after the tick, clearing a stale pin
            open_latch  = (open_count != '0);
            close_latch = (close_count != '0);
        end
        snap.status         = roof_status;
        snap.open_drive     = open_latch;
        snap.close_drive    = close_latch;
        snap.heartbeat_left = hb_count;
        snap.close_left     = close_count;
        snap.open_left      = open_count;
        snap.tripped        = hb_tripped;
        expected_snapshots.push_back(snap);
    endtask

    // ------------------------------------------------------------------
    // Sender. Entered and left at a falling edge. Items go out in bursts;
    // between bursts, when gaps are on, tvalid drops for a random number of cycles, possibly none.
    // ------------------------------------------------------------------
    task automatic send_item(input rdhc_pkg::t_kind kind, input logic [7:0] hbyte,
                             input logic closed_hit, input logic open_hit);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = tx_gaps ? $urandom_range(0, 8) : 0;
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {6'b0, open_hit, closed_hit, hbyte};
        do @(posedge i_clk); while (!o_s_axis_tready);
        roof_predict(kind, hbyte, closed_hit, open_hit);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_host(input logic [7:0] hbyte);
        send_item(rdhc_pkg::KIND_HOST, hbyte, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_tick(input logic closed_hit, input logic open_hit);
        // host byte field is don't-care on ticks; keep it random
        send_item(rdhc_pkg::KIND_TICK, 8'($urandom_range(0, 255)), closed_hit, open_hit);
    endtask

    // ticks with an occasional limit switch hit
    task automatic tick_run(input int unsigned n);
        repeat (n) send_tick($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
    endtask

    // Drop tvalid and wait until every expected item has come back.
    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (expected_snapshots.size() != 0);
    endtask

    // Write one timeout register; only called with the core drained.
    task automatic program_timeout(input logic index,
                                   input logic [rdhc_pkg::CNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == rdhc_pkg::CFG_OPEN_TIMEOUT)
            open_timeout = value;
        else
            close_timeout = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_timeouts(input logic [rdhc_pkg::CNT_W-1:0] open_val,
                                    input logic [rdhc_pkg::CNT_W-1:0] close_val);
        wait_results_drained();
        program_timeout(rdhc_pkg::CFG_OPEN_TIMEOUT, open_val);
        program_timeout(rdhc_pkg::CFG_CLOSE_TIMEOUT, close_val);
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready toggles between random-length ready and stall runs,
    // or stays high when stalls are off.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!rx_stalls) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_ready_phase = !rx_ready_phase;
                rx_left = rx_ready_phase ? $urandom_range(1, 10) : $urandom_range(1, 8);
            end
            rx_left--;
            i_m_axis_tready <= rx_ready_phase;
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input int unsigned exp_val,
                                 input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val,
                     act_val);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_roof_snapshot exp_snap;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_snapshots.size() == 0) begin
                $display("%0t: unexpected result item, expected none actual 0x%08h", $time,
                         o_m_axis_tdata);
                error_count++;
            end else begin
                exp_snap = expected_snapshots.pop_front();
                compare_field("roof_status", exp_snap.status, o_m_axis_tdata[2:0]);
                compare_field("open_drive", exp_snap.open_drive, o_m_axis_tdata[3]);
                compare_field("close_drive", exp_snap.close_drive, o_m_axis_tdata[4]);
                compare_field("heartbeat_left", exp_snap.heartbeat_left, o_m_axis_tdata[12:5]);
                compare_field("close_ticks_left", exp_snap.close_left, o_m_axis_tdata[20:13]);
                compare_field("open_ticks_left", exp_snap.open_left, o_m_axis_tdata[28:21]);
                compare_field("watchdog_tripped", exp_snap.tripped, o_m_axis_tdata[29]);
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, no handshake for %0d cycles", $time, idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every command, the byte extremes, limit priority, stop trim,
    // direction change, heartbeat expiry, lockout while tripped and clear.
    task automatic test_directed_commands();
        send_tick(1'b0, 1'b0);          // idle roof, status unknown
        send_host(rdhc_pkg::CMD_OPEN);
        send_tick(1'b0, 1'b0);          // opening
        send_tick(1'b0, 1'b1);          // open limit ends the open
        send_host(rdhc_pkg::CMD_CLOSE);
        send_tick(1'b1, 1'b1);          // both limits: closed wins
        send_host(rdhc_pkg::CMD_OPEN);
        send_host(rdhc_pkg::CMD_STOP);  // trim to one step
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_host(rdhc_pkg::CMD_CLOSE);
        send_host(rdhc_pkg::CMD_OPEN);  // reverse while closing
        send_tick(1'b0, 1'b0);
        send_host(8'hF4);               // unused command bytes
        send_host(8'hFF);
        send_host(8'hAA);               // heartbeat load
        send_host(8'd2);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);          // heartbeat expires, forced close
        send_host(8'd5);                // ignored while tripped
        send_tick(1'b1, 1'b0);          // force closed
        send_host(rdhc_pkg::HB_OFF);    // clears the trip
        send_host(rdhc_pkg::HB_MAX);
        send_host(8'h55);
        send_tick(1'b0, 1'b1);
    endtask

    // Well-formed motion and heartbeat sequences with random content,
    // mixed with raw noise items.
    task automatic run_random_phase(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned hb_val;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                send_host(rdhc_pkg::CMD_OPEN);
                tick_run($urandom_range(1, 20));
            end else if (pick < 4) begin
                send_host(rdhc_pkg::CMD_CLOSE);
                tick_run($urandom_range(1, 20));
            end else if (pick < 5) begin
                send_host($urandom_range(0, 1) ? rdhc_pkg::CMD_OPEN : rdhc_pkg::CMD_CLOSE);
                tick_run($urandom_range(0, 3));
                send_host(rdhc_pkg::CMD_STOP);
                tick_run($urandom_range(0, 3));
            end else if (pick < 7) begin
                // short heartbeats mostly, so expiry happens often
                hb_val = ($urandom_range(0, 3) == 0) ? $urandom_range(7, rdhc_pkg::HB_MAX)
                                                     : $urandom_range(1, 6);
                send_host(8'(hb_val));
                tick_run((hb_val > 12 ? 12 : hb_val) + $urandom_range(0, 4));
                if ($urandom_range(0, 1))
                    send_host(rdhc_pkg::HB_OFF);
                else
                    send_host(8'($urandom_range(1, rdhc_pkg::HB_MAX)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(rdhc_pkg::t_kind'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Shortest and longest timeouts
    task automatic test_timeout_extremes();
        program_timeouts(8'd1, 8'd1);
        tx_gaps   = 1'b0;   // full-rate stretch
        rx_stalls = 1'b0;
        run_random_phase(100);
        program_timeouts(8'd255, 8'd255);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        run_random_phase(100);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            program_timeouts(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
            tx_gaps   = (phase != 1);
            rx_stalls = (phase != 0);
            run_random_phase(110);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b1;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = 1'b0;
        i_cfg_data      = '0;

        error_count    = 0;
        items_sent     = 0;
        burst_left     = 0;
        idle_cycles    = 0;
        rx_left        = 0;
        rx_ready_phase = 1'b0;
        tx_gaps        = 1'b1;
        rx_stalls      = 1'b1;

        // shadow state mirrors the core's reset values
        open_timeout  = rdhc_pkg::OPEN_TIMEOUT_RST;
        close_timeout = rdhc_pkg::CLOSE_TIMEOUT_RST;
        hb_count      = '0;
        hb_tripped    = 1'b0;
        close_count   = '0;
        open_count    = '0;
        roof_status   = rdhc_pkg::ST_UNKNOWN;
        open_latch    = 1'b0;
        close_latch   = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_commands();
        run_random_phase(60);           // reset timeouts still in effect
        test_timeout_extremes();
        test_random_traffic();

        // let everything out, then watch a few more cycles for strays
        rx_stalls = 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: roof_drive_heartbeat_controller_core.f
rtl/rdhc_pkg.sv
rtl/rdhc_cfg.sv
rtl/rdhc_step.sv
rtl/roof_drive_heartbeat_controller_core.sv
verif/testbench.sv
